>>> hdl/itf_pkg.sv
`timescale 1ns / 1ps
// itf_pkg: item types, conversion codes, ASCII constants and command/status
// structs shared by the integer text formatter. No dependencies.
package itf_pkg;

    // Input item: one conversion request
    typedef struct packed {
        logic [63:0] magnitude;
        logic        negative;
        logic [2:0]  conversion;
        logic        zero_fill;
        logic        left_justify;
        logic        plus_sign;
        logic        space_sign;
        logic        alternate;
        logic        width_valid;
        logic [5:0]  field_width;
        logic        has_precision;
        logic [5:0]  precision;
    } in_item_t;

    // Result item: one character of text
    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_item_t;

    // Conversion kinds
    localparam logic [2:0] CONV_DEC  = 3'd0;
    localparam logic [2:0] CONV_OCT  = 3'd1;
    localparam logic [2:0] CONV_HEXL = 3'd2;
    localparam logic [2:0] CONV_HEXU = 3'd3;
    localparam logic [2:0] CONV_PTR  = 3'd4;
    localparam logic [2:0] CONV_CHAR = 3'd5;

    // ASCII characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic conv_step;
        logic norm_step;
        logic plan;
        logic pad;
        logic emit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic norm_done;
        logic last;
    } sts_t;

    // Map one digit value to its ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_A_UP : CH_A_LO;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'd0, d};
        end else begin
            digit_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

>>> hdl/itf_ctrl.sv
`timescale 1ns / 1ps
// itf_ctrl: sequencing state machine of the integer text formatter.
// Depends on itf_pkg for the command and status structs and conversion codes.
module itf_ctrl #(
    parameter int VALUE_BITS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [2:0]        conversion,
    input  logic              m_ready,
    input  itf_pkg::sts_t     sts,
    output itf_pkg::cmd_t     cmd,
    output logic              s_ready,
    output logic              m_valid
);

    localparam int SW = $clog2(VALUE_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_PLAN,
        ST_PAD,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [SW-1:0]   step_reg, step_next;
    logic            s_ready_reg, s_ready_next;
    logic            m_valid_reg, m_valid_next;
    logic            accept;

    assign accept  = s_valid && s_ready_reg;
    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

    // Issue commands for the current state
    always_comb begin
        cmd           = '0;
        cmd.load      = (state_reg == ST_IDLE) && accept;
        cmd.conv_step = (state_reg == ST_CONV);
        cmd.norm_step = (state_reg == ST_NORM) && !sts.norm_done;
        cmd.plan      = (state_reg == ST_PLAN);
        cmd.pad       = (state_reg == ST_PAD);
        cmd.emit      = (state_reg == ST_EMIT) && m_valid_reg && m_ready;
    end

    // Pick the next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (conversion)
                        itf_pkg::CONV_DEC: begin
                            state_next = ST_CONV;
                            step_next  = SW'(VALUE_BITS - 1);
                        end
                        itf_pkg::CONV_OCT,
                        itf_pkg::CONV_HEXL,
                        itf_pkg::CONV_HEXU,
                        itf_pkg::CONV_PTR: state_next = ST_NORM;
                        itf_pkg::CONV_CHAR: state_next = ST_EMIT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONV: begin
                if (step_reg == '0) begin
                    state_next = ST_NORM;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_NORM: begin
                if (sts.norm_done) begin
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN: state_next = ST_PAD;
            ST_PAD:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (m_ready && sts.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        s_ready_next = (state_next == ST_IDLE);
        m_valid_next = (state_next == ST_EMIT);
    end

    // Hold state and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> hdl/itf_datapath.sv
`timescale 1ns / 1ps
// itf_datapath: digit register with binary-to-BCD shifter, digit normalizer,
// padding planner and character emitter. Depends on itf_pkg.
module itf_datapath #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_FIELD  = 40
) (
    input  logic                 aclk,
    input  itf_pkg::in_item_t    s_item,
    input  itf_pkg::cmd_t        cmd,
    output itf_pkg::sts_t        sts,
    output itf_pkg::out_item_t   m_item
);

    // Octal needs the most digits, so size the digit register for it
    localparam int NDIG    = (VALUE_BITS + 2) / 3;
    localparam int DW      = NDIG * 4;
    localparam int MAX_OUT = MAX_FIELD + 3;
    localparam int CW      = $clog2(MAX_FIELD + NDIG + 4);
    localparam logic [5:0] FW_MAX = 6'(MAX_FIELD);

    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [DW-1:0]         dig_reg, dig_next;
    logic [CW-1:0]         len_reg, len_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  char_mode_reg, char_mode_next;
    logic                  upper_reg, upper_next;
    logic                  hexpfx_reg, hexpfx_next;
    logic                  sign_pend_reg, sign_pend_next;
    logic [7:0]            sign_char_reg, sign_char_next;
    logic [1:0]            rad_reg, rad_next;
    logic                  zp_reg, zp_next;
    logic                  la_reg, la_next;
    logic [5:0]            fw_reg, fw_next;
    logic [5:0]            prec_reg, prec_next;
    logic [CW-1:0]         lz_reg, lz_next;
    logic [CW-1:0]         total_reg, total_next;
    logic [CW-1:0]         lsp_reg, lsp_next;
    logic [CW-1:0]         left_reg, left_next;

    logic [VALUE_BITS-1:0] val_m;
    logic [DW-1:0]         dig_load;
    logic [DW-1:0]         dig_adj;
    logic [3:0]            top_dig;
    logic [2:0]            conv;
    logic                  is_dec, is_oct, is_ptr, is_hex, is_char;
    logic                  alt_eff;
    logic [5:0]            fw_sat, prec_sat, prec_e;
    logic [CW-1:0]         prec_ext, fw_ext, lz_calc, pad, span;
    logic [7:0]            cur_char;

    assign val_m   = s_item.magnitude[VALUE_BITS-1:0];
    assign conv    = s_item.conversion;
    assign is_dec  = (conv == itf_pkg::CONV_DEC);
    assign is_oct  = (conv == itf_pkg::CONV_OCT);
    assign is_ptr  = (conv == itf_pkg::CONV_PTR);
    assign is_char = (conv == itf_pkg::CONV_CHAR);
    assign is_hex  = (conv == itf_pkg::CONV_HEXL) || (conv == itf_pkg::CONV_HEXU) || is_ptr;
    assign alt_eff = is_ptr || (s_item.alternate && !is_dec);
    assign fw_sat   = (s_item.field_width > FW_MAX) ? FW_MAX : s_item.field_width;
    assign prec_sat = (s_item.precision > FW_MAX) ? FW_MAX : s_item.precision;
    assign top_dig  = dig_reg[DW-1 -: 4];
    assign prec_ext = CW'(prec_reg);
    assign fw_ext   = CW'(fw_reg);

    // Octal drops one digit of precision when it carries the 0 prefix
    always_comb begin
        prec_e = s_item.has_precision ? prec_sat : 6'd0;
        if (alt_eff && is_oct && (prec_e != 6'd0)) begin
            prec_e = prec_e - 6'd1;
        end
    end

    // Split the value into digit slots: three bits for octal, four for hex
    always_comb begin
        dig_load = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (is_oct) begin
                dig_load[4*i +: 4] = {1'b0, 3'(val_m >> (3*i))};
            end else if (is_hex) begin
                dig_load[4*i +: 4] = 4'(val_m >> (4*i));
            end
        end
    end

    // Add three to every BCD digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            dig_adj[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ?
                                dig_reg[4*i +: 4] + 4'd3 : dig_reg[4*i +: 4];
        end
    end

    // Planning arithmetic
    assign lz_calc = (prec_ext > len_reg) ? prec_ext - len_reg : '0;
    assign pad     = (fw_ext > total_reg) ? fw_ext - total_reg : '0;
    assign span    = (fw_ext > total_reg) ? fw_ext : total_reg;

    // Select the character of the first segment still pending
    always_comb begin
        if (lsp_reg != '0) begin
            cur_char = itf_pkg::CH_SPACE;
        end else if (sign_pend_reg) begin
            cur_char = sign_char_reg;
        end else if (rad_reg == 2'd2) begin
            cur_char = itf_pkg::CH_ZERO;
        end else if (rad_reg == 2'd1) begin
            if (hexpfx_reg) begin
                cur_char = upper_reg ? itf_pkg::CH_X_UP : itf_pkg::CH_X_LO;
            end else begin
                cur_char = itf_pkg::CH_ZERO;
            end
        end else if (lz_reg != '0) begin
            cur_char = itf_pkg::CH_ZERO;
        end else if (len_reg != '0) begin
            cur_char = char_mode_reg ? byte_reg : itf_pkg::digit_char(top_dig, upper_reg);
        end else begin
            cur_char = itf_pkg::CH_SPACE;
        end
    end

    assign m_item.out_char = cur_char;
    assign m_item.last     = sts.last;
    assign sts.last        = (left_reg == CW'(1));
    assign sts.norm_done   = (top_dig != 4'd0) || (len_reg == CW'(1));

    // Next-state logic of the datapath registers
    always_comb begin
        val_next       = val_reg;
        dig_next       = dig_reg;
        len_next       = len_reg;
        byte_next      = byte_reg;
        char_mode_next = char_mode_reg;
        upper_next     = upper_reg;
        hexpfx_next    = hexpfx_reg;
        sign_pend_next = sign_pend_reg;
        sign_char_next = sign_char_reg;
        rad_next       = rad_reg;
        zp_next        = zp_reg;
        la_next        = la_reg;
        fw_next        = fw_reg;
        prec_next      = prec_reg;
        lz_next        = lz_reg;
        total_next     = total_reg;
        lsp_next       = lsp_reg;
        left_next      = left_reg;

        if (cmd.load) begin
            // Capture the request with flags resolved per conversion kind
            val_next       = val_m;
            dig_next       = dig_load;
            len_next       = is_char ? CW'(1) : CW'(NDIG);
            byte_next      = s_item.magnitude[7:0];
            char_mode_next = is_char;
            upper_next     = (conv == itf_pkg::CONV_HEXU);
            hexpfx_next    = is_hex;
            sign_char_next = itf_pkg::CH_SPACE;
            sign_pend_next = 1'b0;
            if (!is_ptr && !is_char) begin
                if (s_item.negative) begin
                    sign_char_next = itf_pkg::CH_MINUS;
                    sign_pend_next = 1'b1;
                end else if (s_item.plus_sign) begin
                    sign_char_next = itf_pkg::CH_PLUS;
                    sign_pend_next = 1'b1;
                end else if (s_item.space_sign) begin
                    sign_pend_next = 1'b1;
                end
            end
            if (!alt_eff || is_char) begin
                rad_next = 2'd0;
            end else if (is_oct) begin
                rad_next = 2'd1;
            end else begin
                rad_next = 2'd2;
            end
            zp_next   = s_item.zero_fill && !is_ptr && !s_item.has_precision
                        && !s_item.left_justify;
            la_next   = s_item.left_justify && !is_ptr;
            fw_next   = s_item.width_valid ? fw_sat : 6'd0;
            prec_next = prec_e;
            lz_next   = '0;
            lsp_next  = '0;
            left_next = CW'(1);
        end else if (cmd.conv_step) begin
            // Shift one value bit into the BCD digits
            dig_next = {dig_adj[DW-2:0], val_reg[VALUE_BITS-1]};
            val_next = val_reg << 1;
        end else if (cmd.norm_step) begin
            // Drop one leading zero digit
            dig_next = dig_reg << 4;
            len_next = len_reg - CW'(1);
        end else if (cmd.plan) begin
            lz_next    = lz_calc;
            total_next = CW'(sign_pend_reg) + CW'(rad_reg) + lz_calc + len_reg;
        end else if (cmd.pad) begin
            // Width padding goes to zeros or left spaces; right spaces
            // fall out of the character count
            if (!la_reg && zp_reg) begin
                lz_next = lz_reg + pad;
            end else if (!la_reg) begin
                lsp_next = pad;
            end
            left_next = (span > CW'(MAX_OUT)) ? CW'(MAX_OUT) : span;
        end else if (cmd.emit) begin
            // Advance the pending segment
            left_next = left_reg - CW'(1);
            if (lsp_reg != '0) begin
                lsp_next = lsp_reg - CW'(1);
            end else if (sign_pend_reg) begin
                sign_pend_next = 1'b0;
            end else if (rad_reg != 2'd0) begin
                rad_next = rad_reg - 2'd1;
            end else if (lz_reg != '0) begin
                lz_next = lz_reg - CW'(1);
            end else if (len_reg != '0) begin
                len_next = len_reg - CW'(1);
                dig_next = dig_reg << 4;
            end
        end
    end

    // Hold the datapath registers
    always_ff @(posedge aclk) begin
        val_reg       <= val_next;
        dig_reg       <= dig_next;
        len_reg       <= len_next;
        byte_reg      <= byte_next;
        char_mode_reg <= char_mode_next;
        upper_reg     <= upper_next;
        hexpfx_reg    <= hexpfx_next;
        sign_pend_reg <= sign_pend_next;
        sign_char_reg <= sign_char_next;
        rad_reg       <= rad_next;
        zp_reg        <= zp_next;
        la_reg        <= la_next;
        fw_reg        <= fw_next;
        prec_reg      <= prec_next;
        lz_reg        <= lz_next;
        total_reg     <= total_next;
        lsp_reg       <= lsp_next;
        left_reg      <= left_next;
    end

endmodule

>>> hdl/integer_text_formatter.sv
`timescale 1ns / 1ps
// integer_text_formatter: top level, joins the controller and the datapath.
// Depends on itf_pkg, itf_ctrl and itf_datapath.
//
//   channel   ports                       payload                 direction
//   request   s_valid s_ready s_item      itf_pkg::in_item_t      in
//   text      m_valid m_ready m_item      itf_pkg::out_item_t     out
//
// One request at a time. After the accepting edge, decimal converts the value by
// shift-and-add-3 in the BCD digit register. Every numeric kind then drops
// leading zero digits (up to (VALUE_BITS+2)/3 - 1) until it finds the leading
// digit, runs the plan and pad steps, and emits its characters (at most
// MAX_FIELD+3). Char goes straight to its one character. The next request is
// taken the cycle after the last character goes out. Reset is synchronous;
// m_ready low holds the current character.
module integer_text_formatter #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_FIELD  = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  itf_pkg::in_item_t    s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output itf_pkg::out_item_t   m_item
);

    itf_pkg::cmd_t cmd;
    itf_pkg::sts_t sts;

    itf_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .conversion (s_item.conversion),
        .m_ready    (m_ready),
        .sts        (sts),
        .cmd        (cmd),
        .s_ready    (s_ready),
        .m_valid    (m_valid)
    );

    itf_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FIELD  (MAX_FIELD)
    ) u_datapath (
        .aclk   (aclk),
        .s_item (s_item),
        .cmd    (cmd),
        .sts    (sts),
        .m_item (m_item)
    );

    // Never take a request while text is still going out
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request port open while text is pending");

    // Return to accepting right after the final character
    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_item.last |=> s_ready)
        else $error("not ready after final character");

    // A char request yields one character, marked last, on the next cycle
    a_char_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_item.conversion == itf_pkg::CONV_CHAR)
        |=> m_valid && m_item.last)
        else $error("char request did not produce a single final character");

    // An unknown conversion is dropped without text
    a_unknown_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_item.conversion > itf_pkg::CONV_CHAR)
        |=> s_ready && !m_valid)
        else $error("unknown conversion produced text");

endmodule
